### rtl/core/bpa_pkg.sv
// bpa_pkg: shared types, field widths, command and register codes of the
// bitmap page allocator
// no dependencies
package bpa_pkg;

  localparam int ADDR_W      = 48;
  localparam int CMD_W       = 2;
  localparam int COUNT_W     = 2;
  localparam int PAGES_W     = 13;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 48;
  localparam int WORD_BITS   = 64;
  localparam int BIT_W       = 6;
  localparam int CFG_REGIONS = 2;

  // defaults for the top level parameters
  localparam int PAGE_BYTES_DEF       = 4096;
  localparam int PAGES_PER_REGION_DEF = 4096;
  localparam int REGIONS_DEF          = 2;

  // commands
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MARK  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION0_BASE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION0_PAGES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION1_BASE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION1_PAGES = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] addr;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] page_addr;
    logic              found;
  } out_item_t;

  // per-region flags from the region decoder
  typedef struct packed {
    logic [CFG_REGIONS-1:0] en;
    logic [CFG_REGIONS-1:0] hit;
  } rgn_flags_t;

endpackage

### rtl/core/bpa_bitmap_mem.sv
// bpa_bitmap_mem: used-page bitmap storage, one write port and one read
// port with registered read data
// depends on bpa_pkg
module bpa_bitmap_mem #(
  parameter int WORDS = 128,
  parameter int AW    = 7
) (
  input  logic                           clk,
  input  logic                           re,
  input  logic [AW-1:0]                  raddr,
  output logic [bpa_pkg::WORD_BITS-1:0]  rdata,
  input  logic                           we,
  input  logic [AW-1:0]                  waddr,
  input  logic [bpa_pkg::WORD_BITS-1:0]  wdata
);
  import bpa_pkg::*;

  logic [WORD_BITS-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/bpa_region_map.sv
// bpa_region_map: per-region limits and address decode, registered
// gives enable, hit and global bitmap index of an address in each region
// depends on bpa_pkg
module bpa_region_map #(
  parameter int PAGE_BYTES       = 4096,
  parameter int PAGES_PER_REGION = 4096,
  parameter int REGIONS          = 2,
  parameter int IDXW             = 13
) (
  input  logic                                                 clk,
  input  logic [bpa_pkg::COUNT_W-1:0]                          cfg_count,
  input  logic [bpa_pkg::CFG_REGIONS-1:0][bpa_pkg::ADDR_W-1:0]  cfg_base,
  input  logic [bpa_pkg::CFG_REGIONS-1:0][bpa_pkg::PAGES_W-1:0] cfg_pages,
  input  logic [bpa_pkg::ADDR_W-1:0]                           addr,
  output bpa_pkg::rgn_flags_t                                  flags,
  output logic [bpa_pkg::CFG_REGIONS-1:0][IDXW:0]              end_idx,
  output logic [bpa_pkg::CFG_REGIONS-1:0][IDXW-1:0]            hit_idx
);
  import bpa_pkg::*;

  localparam int EW   = IDXW + 1;
  localparam int LPB  = $clog2(PAGE_BYTES);
  localparam int NPW0 = $clog2(PAGES_PER_REGION + 1);
  localparam int NPW  = (NPW0 > PAGES_W) ? NPW0 : PAGES_W;

  for (genvar r = 0; r < CFG_REGIONS; r++) begin : g_rgn
    localparam logic [EW-1:0] START = EW'(r * PAGES_PER_REGION);

    logic [NPW-1:0]    np;
    logic [ADDR_W:0]   lim;
    logic [ADDR_W-1:0] diff;

    // page count clamped to the region size
    assign np = (NPW'(cfg_pages[r]) > NPW'(PAGES_PER_REGION)) ?
                NPW'(PAGES_PER_REGION) : NPW'(cfg_pages[r]);
    assign diff = addr - cfg_base[r];

    always_ff @(posedge clk) begin
      lim          <= {1'b0, cfg_base[r]} + ((ADDR_W + 1)'(np) << LPB);
      end_idx[r]   <= START + EW'(np);
      flags.en[r]  <= (r < REGIONS) && (cfg_count > COUNT_W'(r));
      flags.hit[r] <= flags.en[r] && (addr >= cfg_base[r]) && ({1'b0, addr} < lim);
      hit_idx[r]   <= IDXW'(START) + IDXW'(diff >> LPB);
    end
  end

endmodule

### rtl/core/bitmap_page_allocator_unit.sv
// bitmap_page_allocator_unit: first-fit page allocator over two regions
// sequencer, scan pipeline and configuration registers
// depends on bpa_pkg, bpa_bitmap_mem, bpa_region_map

// One command per input beat, one result beat per command. The used-page
// bitmap lives in a single memory of 64-bit words, (REGIONS*PAGES_PER_REGION)/64
// words, 128 at the default sizes. After reset the block sweeps that memory
// to zero, one word per cycle, and takes no command until the sweep is
// over; configuration writes are taken at any time. Allocate reads one
// bitmap word per cycle through the single read port and stops early when a
// free page turns up. Free and mark-used run a region decode, then a
// read-modify-write of the word in each region that holds the address.
// Regions may overlap; every enabled region holding an address is updated,
// also the other region's copy of a freshly allocated page. A new command is
// taken while the previous result beat still waits on the output.
module bitmap_page_allocator_unit #(
  parameter int PAGE_BYTES       = bpa_pkg::PAGE_BYTES_DEF,        // power of two
  parameter int PAGES_PER_REGION = bpa_pkg::PAGES_PER_REGION_DEF,
  parameter int REGIONS          = bpa_pkg::REGIONS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // command beats
  input  logic                           in_valid,
  output logic                           in_ready,
  input  bpa_pkg::in_item_t              in_data,
  // result beats
  output logic                           out_valid,
  input  logic                           out_ready,
  output bpa_pkg::out_item_t             out_data,
  // configuration writes
  input  logic                           cfg_we,
  input  logic [bpa_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [bpa_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bpa_pkg::*;

  localparam int WORDS = (REGIONS * PAGES_PER_REGION + WORD_BITS - 1) / WORD_BITS;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int IDXW  = AW + BIT_W;
  localparam int EW    = IDXW + 1;
  localparam int LPB   = $clog2(PAGE_BYTES);
  localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,  // zeroing sweep after reset
    S_IDLE  = 8'b0000_0010,
    S_SCAN  = 8'b0000_0100,  // allocate: stream words, look for a clear bit
    S_AWR   = 8'b0000_1000,  // allocate: set the found bit, form the address
    S_MAP   = 8'b0001_0000,  // region decode of op_addr
    S_PRD   = 8'b0010_0000,  // per-region read
    S_PWR   = 8'b0100_0000,  // per-region write back
    S_DONE  = 8'b1000_0000   // hand result to the output register
  } state_t;

  state_t state;

  // configuration
  logic [COUNT_W-1:0]                     cfg_count;
  logic [CFG_REGIONS-1:0][ADDR_W-1:0]     cfg_base;
  logic [CFG_REGIONS-1:0][PAGES_W-1:0]    cfg_pages;

  // bitmap memory port
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;

  // region decode
  rgn_flags_t                          map_flags;
  logic [CFG_REGIONS-1:0][EW-1:0]      map_end;
  logic [CFG_REGIONS-1:0][IDXW-1:0]    map_idx;

  // sweep and scan
  logic [AW-1:0]        clr_w;
  logic [AW-1:0]        scan_w;
  logic                 issued_all;
  logic                 chk_v;
  logic [AW-1:0]        chk_w;
  logic [WORD_BITS-1:0] mask_q;
  logic [WORD_BITS-1:0] mask_next;
  logic [WORD_BITS-1:0] cand;
  logic [BIT_W-1:0]     cand_bit;

  // found page and operation
  logic [AW-1:0]        hit_word;
  logic [BIT_W-1:0]     hit_bit;
  logic [WORD_BITS-1:0] hit_data;
  logic [IDXW-1:0]      hit_gidx;
  logic                 hit_rgn;
  logic [EW-1:0]        hit_page;
  logic [ADDR_W-1:0]    alloc_addr;
  logic [ADDR_W-1:0]    op_addr;
  logic                 set_val;
  logic                 pg_r;
  logic [BIT_W-1:0]     pg_bit;
  logic [WORD_BITS-1:0] pg_mask;
  logic [ADDR_W-1:0]    res_addr;
  logic                 res_found;
  logic                 in_fire;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  // ---------------------------------------------------------------------
  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_count <= '0;
      cfg_base  <= '0;
      cfg_pages <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_REGION_COUNT:  cfg_count    <= cfg_data[COUNT_W-1:0];
        CFG_REGION0_BASE:  cfg_base[0]  <= cfg_data[ADDR_W-1:0];
        CFG_REGION0_PAGES: cfg_pages[0] <= cfg_data[PAGES_W-1:0];
        CFG_REGION1_BASE:  cfg_base[1]  <= cfg_data[ADDR_W-1:0];
        CFG_REGION1_PAGES: cfg_pages[1] <= cfg_data[PAGES_W-1:0];
        default: ;  // indexes past the list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // bitmap storage and region decode
  bpa_bitmap_mem #(
    .WORDS (WORDS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata)
  );

  bpa_region_map #(
    .PAGE_BYTES       (PAGE_BYTES),
    .PAGES_PER_REGION (PAGES_PER_REGION),
    .REGIONS          (REGIONS),
    .IDXW             (IDXW)
  ) u_map (
    .clk       (clk),
    .cfg_count (cfg_count),
    .cfg_base  (cfg_base),
    .cfg_pages (cfg_pages),
    .addr      (op_addr),
    .flags     (map_flags),
    .end_idx   (map_end),
    .hit_idx   (map_idx)
  );

  // ---------------------------------------------------------------------
  // scan datapath
  // a bit of the word being issued is a candidate when its global index
  // lies in an enabled region's tracked range; region 0 sits below region 1
  always_comb begin
    logic [IDXW-1:0] bidx;
    mask_next = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      bidx = {scan_w, BIT_W'(j)};
      for (int r = 0; r < CFG_REGIONS; r++) begin
        if (map_flags.en[r] && (EW'(bidx) >= EW'(r * PAGES_PER_REGION)) &&
            (EW'(bidx) < map_end[r])) begin
          mask_next[j] = 1'b1;
        end
      end
    end
  end

  // lowest clear tracked bit of the word coming back from memory
  assign cand = ~mem_rdata & mask_q;
  always_comb begin
    cand_bit = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (cand[j]) begin
        cand_bit = BIT_W'(j);
      end
    end
  end

  // address of the found page: base of its region plus page offset
  assign hit_gidx   = {hit_word, hit_bit};
  assign hit_rgn    = (EW'(hit_gidx) >= EW'(PAGES_PER_REGION));
  assign hit_page   = EW'(hit_gidx) - (hit_rgn ? EW'(PAGES_PER_REGION) : EW'(0));
  assign alloc_addr = cfg_base[hit_rgn] + (ADDR_W'(hit_page) << LPB);

  // per-region read-modify-write
  assign pg_bit  = map_idx[pg_r][BIT_W-1:0];
  assign pg_mask = WORD_BITS'(1) << pg_bit;

  // ---------------------------------------------------------------------
  // memory port steering
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = scan_w;
    mem_we    = 1'b0;
    mem_waddr = clr_w;
    mem_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_SCAN: begin
        mem_re = !issued_all;
      end
      S_AWR: begin
        mem_we    = 1'b1;
        mem_waddr = hit_word;
        mem_wdata = hit_data | (WORD_BITS'(1) << hit_bit);
      end
      S_PRD: begin
        mem_re    = map_flags.hit[pg_r];
        mem_raddr = map_idx[pg_r][IDXW-1:BIT_W];
      end
      S_PWR: begin
        mem_we    = 1'b1;
        mem_waddr = map_idx[pg_r][IDXW-1:BIT_W];
        mem_wdata = set_val ? (mem_rdata | pg_mask) : (mem_rdata & ~pg_mask);
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_w      <= '0;
      chk_v      <= 1'b0;
      issued_all <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // output register: loaded from S_DONE, emptied when the beat is taken
      if ((state == S_DONE) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_w <= clr_w + AW'(1);
          if (clr_w == LAST_WORD) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            op_addr    <= in_data.addr;
            res_addr   <= '0;
            res_found  <= 1'b0;
            pg_r       <= 1'b0;
            scan_w     <= '0;
            issued_all <= 1'b0;
            chk_v      <= 1'b0;
            case (in_data.cmd)
              CMD_ALLOC: state <= S_SCAN;
              CMD_FREE: begin
                set_val <= 1'b0;
                state   <= S_MAP;
              end
              CMD_MARK: begin
                set_val <= 1'b1;
                state   <= S_MAP;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_SCAN: begin
          // issue stage
          chk_v  <= !issued_all;
          chk_w  <= scan_w;
          mask_q <= mask_next;
          if (!issued_all) begin
            scan_w <= scan_w + AW'(1);
            if (scan_w == LAST_WORD) begin
              issued_all <= 1'b1;
            end
          end
          // check stage; a read still in flight is simply dropped
          if (chk_v && (cand != '0)) begin
            hit_word <= chk_w;
            hit_bit  <= cand_bit;
            hit_data <= mem_rdata;
            state    <= S_AWR;
          end else if (!chk_v && issued_all) begin
            state <= S_DONE;  // no free page anywhere
          end
        end
        S_AWR: begin
          res_addr  <= alloc_addr;
          res_found <= 1'b1;
          op_addr   <= alloc_addr;
          set_val   <= 1'b1;
          state     <= S_MAP;
        end
        S_MAP: begin
          state <= S_PRD;
        end
        S_PRD: begin
          if (map_flags.hit[pg_r]) begin
            state <= S_PWR;
          end else if (pg_r == 1'b1) begin
            state <= S_DONE;
          end else begin
            pg_r <= 1'b1;
          end
        end
        S_PWR: begin
          if (pg_r == 1'b1) begin
            state <= S_DONE;
          end else begin
            pg_r  <= 1'b1;
            state <= S_PRD;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_data.page_addr <= res_addr;
            out_data.found     <= res_found;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // a failed or non-allocate result carries a zero address
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.found) |-> (out_data.page_addr == '0))
    else $error("result without a page carries a nonzero address");

  // every read-modify-write keeps read and write in separate cycles
  assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("bitmap read and write in the same cycle");

  // the bitmap is never written while the sequencer is idle
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mem_we)
    else $error("bitmap written while idle");

  // an accepted command always starts work
  assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state != S_IDLE))
    else $error("accepted command did not leave idle");
`endif

endmodule

### verif/bpa_alloc_checker.sv
`timescale 1ns / 1ps
// bpa_alloc_checker: watches the command, result and configuration ports of
// the page allocator, predicts each result beat and compares it field by field
// depends on bpa_pkg
module bpa_alloc_checker #(
  parameter int PAGE_BYTES       = bpa_pkg::PAGE_BYTES_DEF,
  parameter int PAGES_PER_REGION = bpa_pkg::PAGES_PER_REGION_DEF,
  parameter int REGIONS          = bpa_pkg::REGIONS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  bpa_pkg::in_item_t              in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  bpa_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [bpa_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [bpa_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             results_owed,
  output int                             mismatches
);
  import bpa_pkg::*;

  localparam int MAP_BITS = REGIONS * PAGES_PER_REGION;

  bit                 page_used [MAP_BITS];
  logic [COUNT_W-1:0] reg_count;
  logic [ADDR_W-1:0]  reg_base  [CFG_REGIONS];
  logic [PAGES_W-1:0] reg_pages [CFG_REGIONS];
  out_item_t          pending_page_results [$];

  function automatic int live_regions();
    return (int'(reg_count) > REGIONS) ? REGIONS : int'(reg_count);
  endfunction

  function automatic longint unsigned tracked_pages(int r);
    return (longint'(reg_pages[r]) > PAGES_PER_REGION) ? longint'(PAGES_PER_REGION) :
           longint'(reg_pages[r]);
  endfunction

  // every enabled region holding the address gets its bit updated
  function automatic void set_holding_pages(longint unsigned addr, bit used);
    longint unsigned base;
    longint unsigned lim;
    for (int r = 0; r < live_regions(); r++) begin
      base = 64'(reg_base[r]);
      lim  = base + tracked_pages(r) * PAGE_BYTES;
      if (addr >= base && addr < lim)
        page_used[r * PAGES_PER_REGION + (addr - base) / PAGE_BYTES] = used;
    end
  endfunction

  function automatic out_item_t apply_command(in_item_t item);
    out_item_t       res;
    longint unsigned page_addr;
    res = '0;
    case (item.cmd)
      CMD_ALLOC: begin
        // first fit: regions in order, pages upward
        for (int r = 0; r < live_regions() && !res.found; r++) begin
          for (int p = 0; p < tracked_pages(r); p++) begin
            if (!page_used[r * PAGES_PER_REGION + p]) begin
              page_addr     = longint'(reg_base[r]) + longint'(p) * PAGE_BYTES;
              res.page_addr = page_addr[ADDR_W-1:0];
              res.found     = 1'b1;
              page_used[r * PAGES_PER_REGION + p] = 1'b1;
              set_holding_pages(64'(res.page_addr), 1'b1);
              break;
            end
          end
        end
      end
      CMD_FREE: set_holding_pages(64'(item.addr), 1'b0);
      CMD_MARK: set_holding_pages(64'(item.addr), 1'b1);
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      foreach (page_used[i]) page_used[i] = 1'b0;
      reg_count = '0;
      reg_base  = '{default: '0};
      reg_pages = '{default: '0};
      pending_page_results.delete();
      mismatches = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_page_results.size() == 0) begin
          $display("%0t: unexpected result beat: page_addr %h found %b", $time,
                   out_data.page_addr, out_data.found);
          mismatches++;
        end else begin
          want = pending_page_results.pop_front();
          if (out_data.page_addr !== want.page_addr) begin
            $display("%0t: page_addr expected %h actual %h", $time,
                     want.page_addr, out_data.page_addr);
            mismatches++;
          end
          if (out_data.found !== want.found) begin
            $display("%0t: found expected %b actual %b", $time, want.found,
                     out_data.found);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready)
        pending_page_results.push_back(apply_command(in_data));
      if (cfg_we) begin
        case (cfg_idx)
          CFG_REGION_COUNT:  reg_count    = cfg_data[COUNT_W-1:0];
          CFG_REGION0_BASE:  reg_base[0]  = cfg_data[ADDR_W-1:0];
          CFG_REGION0_PAGES: reg_pages[0] = cfg_data[PAGES_W-1:0];
          CFG_REGION1_BASE:  reg_base[1]  = cfg_data[ADDR_W-1:0];
          CFG_REGION1_PAGES: reg_pages[1] = cfg_data[PAGES_W-1:0];
          default: ;
        endcase
      end
    end
    results_owed = pending_page_results.size();
  end

endmodule

### verif/bitmap_page_allocator_unit_test.sv
`timescale 1ns / 1ps
// bitmap_page_allocator_unit_test: drives commands and region settings into the
// page allocator and gives the verdict from the checker's mismatch count
// depends on bpa_pkg, bpa_alloc_checker, bitmap_page_allocator_unit
module bitmap_page_allocator_unit_test;
  import bpa_pkg::*;

  localparam int RANDOM_ITEMS = 1550;
  localparam int STALL_LIMIT  = 4000;   // cycles with no beat on either channel
  localparam int HOLD_CYCLES  = 400;    // long result back-pressure stretch
  localparam int DRAIN_CYCLES = 160;    // a little over the longest allocate scan
  localparam int MAX_PAGES    = (1 << PAGES_W) - 1;

  localparam longint unsigned PAGE     = PAGE_BYTES_DEF;
  localparam longint unsigned ADDR_TOP = 64'h1_0000_0000_0000;   // 2^48
  localparam longint unsigned ADDR_MAX = ADDR_TOP - 1;
  localparam longint unsigned BASE_A   = 64'h0000_1234_5000;
  localparam longint unsigned BASE_B   = 64'h0000_8000_0000;

  // the one command code the package leaves unnamed
  localparam logic [CMD_W-1:0]     CMD_NONE     = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LAST = '1;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  int results_owed;
  int mismatches;

  // idle percentages per side, changed as the run goes on
  int send_idle_pct = 21;
  int recv_idle_pct = 83;
  bit hold_results  = 1'b0;
  int quiet_cycles  = 0;

  // stimulus-side copy of the region settings, only used to aim addresses
  longint unsigned stim_base  [CFG_REGIONS];
  int              stim_pages [CFG_REGIONS];
  int              phase_allocs;

  bitmap_page_allocator_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data)
  );

  bpa_alloc_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_data     (cfg_data),
    .results_owed (results_owed),
    .mismatches   (mismatches)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // result side: random stalls, plus one long hold-off on request so the
  // block backs up and drops in_ready while commands keep coming
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_results) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_results = 1'b0;
      end
      out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // watchdog: any beat on either channel restarts the count
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("bitmap_page_allocator_unit_test: FAIL");
      $finish;
    end
  end

  // one register write, taken at the next rising edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // all five registers; junk above each narrow field checks the width masking
  task automatic set_regions(input int count, input longint unsigned b0, input int p0,
                             input longint unsigned b1, input int p1);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'({$urandom, $urandom});
    write_reg(CFG_REGION_COUNT,  {junk[CFG_DATA_W-1:COUNT_W], count[COUNT_W-1:0]});
    write_reg(CFG_REGION0_BASE,  b0[ADDR_W-1:0]);
    write_reg(CFG_REGION0_PAGES, {junk[CFG_DATA_W-1:PAGES_W], p0[PAGES_W-1:0]});
    write_reg(CFG_REGION1_BASE,  b1[ADDR_W-1:0]);
    write_reg(CFG_REGION1_PAGES, {junk[CFG_DATA_W-1:PAGES_W], p1[PAGES_W-1:0]});
    stim_base[0]  = 64'(b0[ADDR_W-1:0]);
    stim_base[1]  = 64'(b1[ADDR_W-1:0]);
    stim_pages[0] = int'(p0[PAGES_W-1:0]);
    stim_pages[1] = int'(p1[PAGES_W-1:0]);
    phase_allocs  = 0;
  endtask

  // valid goes up after the random idle and stays up until the beat is taken;
  // returns at the falling edge after the handshake with valid still up, so
  // the caller either sends again at once or lowers it
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_data.cmd  = cmd;
    in_data.addr = addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // block is idle once every result beat owed has come back
  task automatic wait_idle();
    in_valid = 1'b0;
    while (results_owed != 0) @(negedge clk);
  endtask

  function automatic int pick_pages();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind == 0) return 0;
    if (kind == 1) return PAGES_PER_REGION_DEF;
    if (kind == 2) return $urandom_range(PAGES_PER_REGION_DEF + 1, MAX_PAGES);
    return $urandom_range(1, 48);   // small regions fill up and exercise a full map
  endfunction

  function automatic longint unsigned pick_base();
    int kind;
    longint unsigned b;
    kind = $urandom_range(0, 9);
    b = {$urandom, $urandom};
    if (kind == 0) return b;                                   // not page aligned
    if (kind == 1) return ADDR_TOP - PAGE * $urandom_range(1, 8); // allocs may wrap
    return b & ~(PAGE - 1);
  endfunction

  task automatic pick_regions();
    int              kind;
    int              count;
    int              p0;
    int              p1;
    longint unsigned b0;
    longint unsigned b1;
    kind  = $urandom_range(0, 9);
    count = (kind == 0) ? 0 : (kind == 1) ? 3 : (kind < 5) ? 1 : 2;
    p0    = pick_pages();
    p1    = pick_pages();
    b0    = pick_base();
    // overlapping regions about a third of the time
    if ($urandom_range(0, 9) < 3) begin
      b1 = b0 + PAGE * $urandom_range(0, p0);
    end else begin
      b1 = pick_base();
    end
    if ($urandom_range(0, 3) == 0)
      write_reg(CFG_IDX_W'($urandom_range(CFG_REGION1_PAGES + 1, CFG_IDX_LAST)),
                CFG_DATA_W'({$urandom, $urandom}));
    set_regions(count, b0, p0, b1, p1);
  endtask

  // mostly addresses inside a region near the pages handed out so far,
  // plus bounds, extremes and plain noise
  function automatic logic [ADDR_W-1:0] pick_addr();
    int              kind;
    int              r;
    int              np;
    int              span;
    longint unsigned a;
    kind = $urandom_range(0, 19);
    r    = $urandom_range(0, CFG_REGIONS - 1);
    np   = (stim_pages[r] > PAGES_PER_REGION_DEF) ? PAGES_PER_REGION_DEF : stim_pages[r];
    span = (phase_allocs + 4 < np) ? phase_allocs + 4 : np;
    if (kind == 0) begin
      a = {$urandom, $urandom};
    end else if (kind == 1) begin
      a = 0;
    end else if (kind == 2) begin
      a = ADDR_MAX;
    end else if (kind == 3) begin
      a = stim_base[r] + np * PAGE;   // first address past the region
    end else if (kind == 4) begin
      a = stim_base[r] - 1;
    end else begin
      a = stim_base[r] + PAGE * $urandom_range(0, (span > 0) ? span - 1 : 0)
          + $urandom_range(0, PAGE - 1);
    end
    return a[ADDR_W-1:0];
  endfunction

  initial begin
    int               sent;
    int               phase;
    int               n;
    int               kind;
    logic [CMD_W-1:0] cmd;

    rst      = 1'b1;
    in_valid = 1'b0;
    in_data  = '0;
    cfg_we   = 1'b0;
    cfg_idx  = '0;
    cfg_data = '0;
    stim_base    = '{default: 0};
    stim_pages   = '{default: 0};
    phase_allocs = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: no region enabled, so nothing allocates or changes
    send_cmd(CMD_ALLOC, ADDR_W'(ADDR_MAX));
    send_cmd(CMD_MARK, '0);
    send_cmd(CMD_NONE, ADDR_W'(ADDR_MAX));
    wait_idle();

    // two small disjoint regions, four and three pages
    set_regions(2, BASE_A, 4, BASE_B, 3);
    write_reg(CFG_IDX_LAST, CFG_DATA_W'(ADDR_MAX));   // unused index, ignored
    repeat (8) send_cmd(CMD_ALLOC, ADDR_W'({$urandom, $urandom}));   // last one finds no page
    send_cmd(CMD_FREE, ADDR_W'(BASE_A + PAGE));
    send_cmd(CMD_FREE, ADDR_W'(BASE_B + 3 * PAGE - 1));    // last byte of the top page
    send_cmd(CMD_FREE, ADDR_W'(BASE_A + 4 * PAGE));        // exclusive bound, no effect
    send_cmd(CMD_FREE, ADDR_W'(BASE_A - 1));               // below the region
    send_cmd(CMD_ALLOC, '0);
    send_cmd(CMD_ALLOC, '0);
    send_cmd(CMD_ALLOC, '0);
    send_cmd(CMD_FREE, ADDR_W'(BASE_A + 4 * PAGE - 1));
    send_cmd(CMD_MARK, ADDR_W'(BASE_A + 3 * PAGE));
    send_cmd(CMD_ALLOC, '0);
    wait_idle();

    // count and page count clamp; region one overlaps the top of region zero
    // and region zero runs past the end of the address space
    set_regions(3, ADDR_TOP - 6 * PAGE, MAX_PAGES, ADDR_TOP - 2 * PAGE, 4);
    send_cmd(CMD_ALLOC, '0);
    send_cmd(CMD_ALLOC, '0);                      // also marks region one's copy
    send_cmd(CMD_ALLOC, '0);                      // address wraps to zero
    send_cmd(CMD_FREE, ADDR_W'(ADDR_TOP - PAGE)); // clears the page in both regions
    send_cmd(CMD_ALLOC, '0);
    wait_idle();

    // random phases, each with fresh region settings
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      if (phase == 0) begin
        set_regions(2, 0, PAGES_PER_REGION_DEF, ADDR_TOP - PAGE * PAGES_PER_REGION_DEF,
                    PAGES_PER_REGION_DEF);
      end else if (phase == 1) begin
        set_regions(3, ADDR_MAX, MAX_PAGES, pick_base(), 0);
      end else begin
        pick_regions();
      end
      phase++;
      n = $urandom_range(60, 160);
      for (int k = 0; k < n && sent < RANDOM_ITEMS; k++) begin
        if (sent < RANDOM_ITEMS / 3) begin
          send_idle_pct = 21;
          recv_idle_pct = 83;
        end else if (sent < 2 * RANDOM_ITEMS / 3) begin
          send_idle_pct = 83;
          recv_idle_pct = 21;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        // back-pressure burst right as the sender goes full rate
        if (sent == 2 * RANDOM_ITEMS / 3) hold_results = 1'b1;
        kind = $urandom_range(0, 19);
        if (kind < 9) begin
          cmd = CMD_ALLOC;
          phase_allocs++;
        end else if (kind < 14) begin
          cmd = CMD_FREE;
        end else if (kind < 18) begin
          cmd = CMD_MARK;
        end else begin
          cmd = CMD_NONE;
        end
        send_cmd(cmd, pick_addr());
        sent++;
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("bitmap_page_allocator_unit_test: PASS");
    end else begin
      $display("bitmap_page_allocator_unit_test: FAIL");
    end
    $finish;
  end

endmodule
